>>> hdl/vector_distance_multi_metric_defines.svh
// Assertion macros for the vector distance RTL, included by vdm_back.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef VECTOR_DISTANCE_MULTI_METRIC_DEFINES_SVH
`define VECTOR_DISTANCE_MULTI_METRIC_DEFINES_SVH
`define VDM_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("vdm assertion failed");
`define VDM_ASSERT_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (pre) |=> (post)) else $error("vdm assertion failed");
`endif

>>> hdl/vdm_pkg.sv
// Package for the vector distance block: payload structs, codes and constants.
// Depends on nothing; used by every module of the block.
`default_nettype none
package vdm_pkg;
	localparam int ELEM_WIDTH = 16;
	localparam int ACC_W = 40;
	localparam int DIST_W = 22;
	localparam int MAX_ELEMS_DEF = 64;
	localparam int QDEPTH = 2;
	localparam logic [1:0] METRIC_EUC = 2'd0;
	localparam logic [1:0] METRIC_MAN = 2'd1;
	localparam logic [ACC_W-1:0] ACC_UMAX = {ACC_W{1'b1}};
	localparam logic [ACC_W-1:0] ACC_SMAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_SMIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0] COS_ONE = DIST_W'(16384);

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] a_elem;
		logic signed [ELEM_WIDTH-1:0] b_elem;
		logic last;
	} vdm_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic zero_norm;
	} vdm_out_t;

	typedef struct packed {
		logic [1:0] metric;
		logic [ACC_W-1:0] diff;
		logic signed [ACC_W-1:0] dot;
		logic [ACC_W-1:0] norm_a;
		logic [ACC_W-1:0] norm_b;
	} vdm_snap_t;
endpackage
`default_nettype wire

>>> hdl/vdm_front.sv
// Front part: accepts element pairs, multiplies, and keeps the running sums.
// Depends on vdm_pkg; pushes one sum snapshot per vector into the queue.
`default_nettype none
module vdm_front #(
	parameter int MAX_ELEMS = vdm_pkg::MAX_ELEMS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [1:0] metric,
	input wire logic in_valid,
	output logic in_stall,
	input wire vdm_pkg::vdm_in_t in_data,
	input wire logic q_full,
	output logic q_push,
	output vdm_pkg::vdm_snap_t q_data
);
	import vdm_pkg::*;
	localparam int CNT_W = $clog2(MAX_ELEMS + 1);
	localparam int SQ_W = 2 * (ELEM_WIDTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic valid_s1, use_s1, last_s1, euc_s1;
	logic [SQ_W-1:0] sqd_s1;
	logic [ELEM_WIDTH:0] absd_s1;
	logic signed [2*ELEM_WIDTH-1:0] ab_s1;
	logic [2*ELEM_WIDTH-1:0] aa_s1, bb_s1;
	logic [ACC_W-1:0] diff_q, na_q, nb_q;
	logic signed [ACC_W-1:0] dot_q;
	logic [ACC_W-1:0] diff_n, na_n, nb_n;
	logic signed [ACC_W-1:0] dot_n;
	logic accept, go;
	logic signed [ELEM_WIDTH:0] d;
	logic [ELEM_WIDTH:0] dm;
	logic [ELEM_WIDTH-1:0] ma, mb;

	function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc, logic [ACC_W-1:0] x);
		logic [ACC_W:0] s;
		s = {1'b0, acc} + {1'b0, x};
		return s[ACC_W] ? ACC_UMAX : s[ACC_W-1:0];
	endfunction

	assign go = !(last_s1 && q_full);
	assign in_stall = valid_s1 && !go;
	assign accept = in_valid && !in_stall;

	always_comb begin
		d = (ELEM_WIDTH+1)'(in_data.a_elem) - (ELEM_WIDTH+1)'(in_data.b_elem);
		dm = d[ELEM_WIDTH] ? (ELEM_WIDTH+1)'(-d) : d;
		ma = in_data.a_elem[ELEM_WIDTH-1] ? ELEM_WIDTH'(-in_data.a_elem) : in_data.a_elem;
		mb = in_data.b_elem[ELEM_WIDTH-1] ? ELEM_WIDTH'(-in_data.b_elem) : in_data.b_elem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (in_data.last) begin
					cnt_q <= '0;
				end else if (cnt_q < CNT_W'(MAX_ELEMS)) begin
					cnt_q <= cnt_q + 1'b1;
				end
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_s1 <= cnt_q < CNT_W'(MAX_ELEMS);
			last_s1 <= in_data.last;
			euc_s1 <= metric == METRIC_EUC;
			sqd_s1 <= SQ_W'(dm) * SQ_W'(dm);
			absd_s1 <= dm;
			ab_s1 <= in_data.a_elem * in_data.b_elem;
			aa_s1 <= (2*ELEM_WIDTH)'(ma) * (2*ELEM_WIDTH)'(ma);
			bb_s1 <= (2*ELEM_WIDTH)'(mb) * (2*ELEM_WIDTH)'(mb);
		end
	end

	always_comb begin
		logic signed [ACC_W:0] s;
		s = '0;
		diff_n = diff_q;
		dot_n = dot_q;
		na_n = na_q;
		nb_n = nb_q;
		if (use_s1) begin
			diff_n = sat_add(diff_q, euc_s1 ? ACC_W'(sqd_s1) : ACC_W'(absd_s1));
			s = {dot_q[ACC_W-1], dot_q} + (ACC_W+1)'(ab_s1);
			dot_n = (s[ACC_W] != s[ACC_W-1]) ? (s[ACC_W] ? ACC_SMIN : ACC_SMAX)
				: s[ACC_W-1:0];
			na_n = sat_add(na_q, ACC_W'(aa_s1));
			nb_n = sat_add(nb_q, ACC_W'(bb_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
		end else if (valid_s1 && go) begin
			if (last_s1) begin
				diff_q <= '0;
				dot_q <= '0;
				na_q <= '0;
				nb_q <= '0;
			end else begin
				diff_q <= diff_n;
				dot_q <= dot_n;
				na_q <= na_n;
				nb_q <= nb_n;
			end
		end
	end

	assign q_push = valid_s1 && go && last_s1;
	assign q_data = '{metric: metric, diff: diff_n, dot: dot_n, norm_a: na_n, norm_b: nb_n};
endmodule
`default_nettype wire

>>> hdl/vdm_queue.sv
// Short queue of per-vector sum snapshots between front and back parts.
// Depends on vdm_pkg for the snapshot type and depth.
`default_nettype none
module vdm_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire vdm_pkg::vdm_snap_t push_data,
	output logic full,
	input wire logic pop,
	output logic avail,
	output vdm_pkg::vdm_snap_t pop_data
);
	import vdm_pkg::*;
	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	vdm_snap_t mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0] cnt_q;

	function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = cnt_q == (PTR_W+1)'(QDEPTH);
	assign avail = cnt_q != '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= inc(wr_q);
			end
			if (pop) begin
				rd_q <= inc(rd_q);
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

>>> hdl/vdm_back.sv
// Back part: square roots, multiply and divide that turn sums into a distance.
// Depends on vdm_pkg and the assertion macro header; feeds the result register.
`default_nettype none
`include "vector_distance_multi_metric_defines.svh"
module vdm_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_avail,
	input wire vdm_pkg::vdm_snap_t q_data,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_stall,
	output vdm_pkg::vdm_out_t out_data
);
	import vdm_pkg::*;
	localparam int SV_W = 48;
	localparam int RT_W = SV_W / 2;
	localparam int DEN_W = 2 * RT_W;
	localparam int NUM_W = ACC_W + 22;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQA = 3'd1;
	localparam logic [2:0] ST_SQB = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_OVF = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_FIN = 3'd6;

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic euc_q, neg_q, zn_q;
	logic [ACC_W-1:0] nb_q;
	logic [SV_W-1:0] sv_q, sb_q;
	logic [SV_W:0] sr_q;
	logic [RT_W-1:0] ra_q, rb_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] rem_q, dv_q;
	logic [14:0] quo_q;
	logic [14:0] quo_n;
	logic [DIST_W-1:0] res_q;
	logic [SV_W-1:0] sv_n;
	logic [SV_W:0] sr_n, tr;
	logic [ACC_W-1:0] mdot;
	logic [DIST_W-1:0] c;

	always_comb begin
		tr = sr_q + {1'b0, sb_q};
		if ({1'b0, sv_q} >= tr) begin
			sv_n = sv_q - tr[SV_W-1:0];
			sr_n = (sr_q >> 1) + {1'b0, sb_q};
		end else begin
			sv_n = sv_q;
			sr_n = sr_q >> 1;
		end
		mdot = q_data.dot[ACC_W-1] ? ACC_W'(-q_data.dot) : q_data.dot;
		quo_n = {quo_q[13:0], rem_q >= dv_q};
		c = ({7'd0, quo_n} > COS_ONE) ? COS_ONE : {7'd0, quo_n};
	end

	assign q_pop = (state_q == ST_IDLE) && q_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_avail) begin
						cnt_q <= '0;
						if (q_data.metric == METRIC_MAN) begin
							state_q <= ST_FIN;
						end else if (q_data.metric == METRIC_EUC) begin
							state_q <= ST_SQA;
						end else if (q_data.norm_a == '0 || q_data.norm_b == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SQA;
						end
					end
				end
				ST_SQA, ST_SQB: begin
					if (cnt_q == 5'(RT_W - 1)) begin
						cnt_q <= '0;
						if (state_q == ST_SQB) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= euc_q ? ST_FIN : ST_SQB;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: state_q <= ST_OVF;
				ST_OVF: begin
					state_q <= ({1'b0, rem_q} >= ({15'd0, den_q} << 15)) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd14) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				euc_q <= q_data.metric == METRIC_EUC;
				neg_q <= q_data.dot[ACC_W-1];
				nb_q <= q_data.norm_b;
				rem_q <= NUM_W'(mdot) << 22;
				quo_q <= '0;
				sr_q <= '0;
				sb_q <= SV_W'(1) << (SV_W - 2);
				zn_q <= 1'b0;
				if (q_data.metric == METRIC_MAN) begin
					res_q <= (q_data.diff > ACC_W'(DIST_MAX)) ? DIST_MAX
						: q_data.diff[DIST_W-1:0];
				end else if (q_data.metric == METRIC_EUC) begin
					sv_q <= SV_W'(q_data.diff);
				end else begin
					sv_q <= SV_W'(q_data.norm_a) << 8;
					res_q <= COS_ONE;
					zn_q <= 1'b1;
				end
			end
			ST_SQA, ST_SQB: begin
				if (cnt_q == 5'(RT_W - 1) && state_q == ST_SQA) begin
					ra_q <= sr_n[RT_W-1:0];
					res_q <= DIST_W'(sr_n[RT_W-1:0]);
					sv_q <= SV_W'(nb_q) << 8;
					sr_q <= '0;
					sb_q <= SV_W'(1) << (SV_W - 2);
				end else begin
					sv_q <= sv_n;
					sr_q <= sr_n;
					sb_q <= sb_q >> 2;
					if (cnt_q == 5'(RT_W - 1)) begin
						rb_q <= sr_n[RT_W-1:0];
					end
				end
			end
			ST_MUL: den_q <= DEN_W'(ra_q) * DEN_W'(rb_q);
			ST_OVF: begin
				zn_q <= 1'b0;
				dv_q <= NUM_W'(den_q) << 14;
				res_q <= neg_q ? (COS_ONE + COS_ONE) : '0;
			end
			ST_DIV: begin
				if (rem_q >= dv_q) begin
					rem_q <= rem_q - dv_q;
				end
				quo_q <= quo_n;
				dv_q <= dv_q >> 1;
				if (cnt_q == 5'd14) begin
					res_q <= neg_q ? COS_ONE + c : COS_ONE - c;
				end
			end
			ST_FIN: begin
				if (!out_valid || !out_stall) begin
					out_data.zero_norm <= zn_q;
					out_data.distance <= res_q;
				end
			end
			default: ;
		endcase
	end

	`VDM_ASSERT(pop_only_idle, q_pop |-> state_q == ST_IDLE)
	`VDM_ASSERT(zero_norm_is_one, out_valid && out_data.zero_norm |-> out_data.distance == COS_ONE)
	`VDM_ASSERT_NEXT(fin_leaves, state_q == ST_FIN && !out_valid, out_valid && state_q == ST_IDLE)
endmodule
`default_nettype wire

>>> hdl/vector_distance_multi_metric.sv
// Top level of the vector distance block: config register, front, queue, back.
// Depends on vdm_pkg, vdm_front, vdm_queue and vdm_back.
//
// Usage: element pairs enter on in_valid/in_stall/in_data, one request per cycle while in_stall is low.
// A request with last set closes the vector; one result per vector leaves on
// out_valid/out_stall/out_data and is held while out_stall is high.
// cfg_we/cfg_wdata write the metric: 0 euclidean, 1 manhattan, 2 or 3 cosine.
// Throughput: one pair per cycle in the front multiply-accumulate pipeline while in_stall is low.
// Manhattan and zero-norm cosine results go straight to the result register;
// euclidean takes one root and cosine two roots, a multiply, an overflow check
// and, unless the ratio clamps at one, the 15-step divider. The back part has
// a one-bit-per-cycle square root unit (24 steps per root).
// The back part finishes one vector at a time; a two-entry snapshot queue lets
// the front keep streaming up to two finished vectors ahead of it, after which
// in_stall rises on the next last pair.
// Reset clears the sums, the metric, the queue and the result valid.
// A stalled receiver holds the result; the back part then waits at its end.
`default_nettype none
module vector_distance_multi_metric #(
	parameter int MAX_ELEMS = vdm_pkg::MAX_ELEMS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire vdm_pkg::vdm_in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output vdm_pkg::vdm_out_t out_data
);
	import vdm_pkg::*;

	logic [1:0] metric_q;
	logic q_push, q_full, q_pop, q_avail;
	vdm_snap_t q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= METRIC_EUC;
		end else if (cfg_we) begin
			metric_q <= cfg_wdata;
		end
	end

	vdm_front #(.MAX_ELEMS(MAX_ELEMS)) u_front (
		.clk(clk), .arst_n(arst_n), .metric(metric_q),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.q_full(q_full), .q_push(q_push), .q_data(q_in)
	);

	vdm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .avail(q_avail), .pop_data(q_out)
	);

	vdm_back u_back (
		.clk(clk), .arst_n(arst_n), .q_avail(q_avail), .q_data(q_out), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule
`default_nettype wire
